// ----- hw/rtl/sbmq_pkg.sv -----
// ----------------------------------------------------------------------------
// Shared buffer multi-queue package
// Types, codes and default sizes shared by the multi-queue unit and its testbench.
// ----------------------------------------------------------------------------
package sbmq_pkg;

  // Default sizes of the shared store.
  localparam int ENTRIES_DEF    = 64;
  localparam int QUEUES_DEF     = 8;
  localparam int DATA_WIDTH_DEF = 32;

  // Operation codes carried in the command field.
  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } command_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } status_t;

  // One input transaction.
  typedef struct packed {
    command_t           command;
    logic [2:0]         queue_number;
    logic signed [31:0] push_value;
  } op_t;

  // One result transaction.
  typedef struct packed {
    status_t            status;
    logic signed [31:0] pop_value;
  } result_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PUSH,
    S_POP_RD,
    S_POP_WR
  } state_t;

endpackage

// ----- hw/rtl/sbmq_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module sbmq_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/shared_buffer_multi_queue_unit.sv -----
// ----------------------------------------------------------------------------
// Shared buffer multi-queue unit
// Several FIFO queues kept as linked lists in one shared entry store, with a
// free list threading all unused entries.
// ----------------------------------------------------------------------------
// A push passes S_PUSH and a pop S_POP_RD and S_POP_WR before done; a pop
// of an empty queue ends in S_POP_RD, and an overflow or a bad queue number
// is answered in S_IDLE. Busy drops with done, so the next transaction can
// start in the result cycle. The steps come from the dependent registered
// RAM reads and the single link RAM write port. After reset busy stays high
// while the link and queue RAMs are swept. Results cannot be stalled.
module shared_buffer_multi_queue_unit #(
  parameter int ENTRIES    = sbmq_pkg::ENTRIES_DEF,
  parameter int QUEUES     = sbmq_pkg::QUEUES_DEF,
  parameter int DATA_WIDTH = sbmq_pkg::DATA_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  sbmq_pkg::op_t     op,
  output logic              done,
  output sbmq_pkg::result_t result
);

  localparam int AW      = $clog2(ENTRIES);
  localparam int PW      = $clog2(ENTRIES + 1);
  localparam int QAW     = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int CLR_LEN = (ENTRIES > QUEUES) ? ENTRIES : QUEUES;
  localparam int CW      = $clog2(CLR_LEN);
  localparam logic [PW-1:0] NIL = PW'(ENTRIES);

  // A pointer names an entry when it is below ENTRIES; anything else is null.
  function automatic logic is_entry(input logic [PW-1:0] p);
    is_entry = (p < NIL);
  endfunction

  sbmq_pkg::state_t  state, state_next;
  logic [PW-1:0]     free_head, free_head_next;
  logic [CW-1:0]     clr, clr_next;
  sbmq_pkg::op_t     op_reg;
  logic [PW-1:0]     pop_head, pop_tail;
  logic [PW-1:0]     pop_head_next, pop_tail_next;
  logic              done_next;
  sbmq_pkg::result_t result_next;
  logic              accept;

  // Link RAM ports.
  logic              link_we;
  logic [AW-1:0]     link_waddr, link_raddr;
  logic [PW-1:0]     link_wdata, link_rdata;

  // Queue RAM ports: each word holds {head, tail}.
  logic              q_we;
  logic [QAW-1:0]    q_waddr, q_raddr;
  logic [2*PW-1:0]   q_wdata, q_rdata;

  // Data RAM ports.
  logic                  data_we;
  logic [AW-1:0]         data_waddr, data_raddr;
  logic [DATA_WIDTH-1:0] data_wdata, data_rdata;

  logic [PW-1:0] rd_head, rd_tail, link_next_head;
  logic          q_ok;

  sbmq_ram #(.WIDTH(PW), .DEPTH(ENTRIES), .ADDR_W(AW)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  sbmq_ram #(.WIDTH(2 * PW), .DEPTH(QUEUES), .ADDR_W(QAW)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  sbmq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(ENTRIES), .ADDR_W(AW)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (data_waddr),
    .wdata (data_wdata),
    .raddr (data_raddr),
    .rdata (data_rdata)
  );

  assign busy    = (state != sbmq_pkg::S_IDLE);
  assign accept  = start && !busy;
  assign q_ok    = (int'(op.queue_number) < QUEUES);
  assign rd_head = q_rdata[2*PW-1:PW];
  assign rd_tail = q_rdata[PW-1:0];

  // The tail's link is never kept up to date, so a pop of the last entry
  // is recognized by head equal to tail.
  assign link_next_head = ((pop_head == pop_tail) || !is_entry(link_rdata)) ?
                          NIL : link_rdata;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sbmq_pkg::S_CLEAR;
      free_head <= '0;
      clr       <= '0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      free_head <= free_head_next;
      clr       <= clr_next;
      done      <= done_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_reg <= op;
    end
    pop_head <= pop_head_next;
    pop_tail <= pop_tail_next;
    result   <= result_next;
  end

  // Sequencer. RAM accesses never overlap: reads are issued only in the
  // accept cycle or the pop read cycle, writes only in the last or a clear cycle.
  always_comb begin
    state_next     = state;
    free_head_next = free_head;
    clr_next       = clr;
    pop_head_next  = pop_head;
    pop_tail_next  = pop_tail;
    done_next      = 1'b0;
    result_next    = result;

    link_we    = 1'b0;
    link_waddr = free_head[AW-1:0];
    link_wdata = NIL;
    link_raddr = free_head[AW-1:0];
    q_we       = 1'b0;
    q_waddr    = QAW'(op_reg.queue_number);
    q_wdata    = {NIL, NIL};
    q_raddr    = QAW'(op.queue_number);
    data_we    = 1'b0;
    data_waddr = free_head[AW-1:0];
    data_wdata = DATA_WIDTH'($unsigned(op_reg.push_value));
    data_raddr = pop_head[AW-1:0];

    case (state)
      // Build the initial free list and empty every queue.
      sbmq_pkg::S_CLEAR: begin
        link_we    = (int'(clr) < ENTRIES);
        link_waddr = AW'(clr);
        link_wdata = PW'(int'(clr) + 1);
        q_we       = (int'(clr) < QUEUES);
        q_waddr    = QAW'(clr);
        q_wdata    = {NIL, NIL};
        clr_next   = CW'(int'(clr) + 1);
        if (int'(clr) == CLR_LEN - 1) begin
          state_next = sbmq_pkg::S_IDLE;
        end
      end

      // Take a transaction; reject the ones decided by registers alone.
      sbmq_pkg::S_IDLE: begin
        if (accept) begin
          if (op.command == sbmq_pkg::CMD_PUSH) begin
            if (!q_ok || !is_entry(free_head)) begin
              done_next          = 1'b1;
              result_next.status = sbmq_pkg::STATUS_OVERFLOW;
              result_next.pop_value = '0;
            end else begin
              state_next = sbmq_pkg::S_PUSH;
            end
          end else begin
            if (!q_ok) begin
              done_next          = 1'b1;
              result_next.status = sbmq_pkg::STATUS_UNDERFLOW;
              result_next.pop_value = '0;
            end else begin
              state_next = sbmq_pkg::S_POP_RD;
            end
          end
        end
      end

      // Link the free-list head behind the tail, if any, and store the value.
      sbmq_pkg::S_PUSH: begin
        free_head_next = link_rdata;
        data_we        = 1'b1;
        q_we           = 1'b1;
        if (!is_entry(rd_head)) begin
          q_wdata = {free_head, free_head};
        end else begin
          q_wdata    = {rd_head, free_head};
          link_we    = 1'b1;
          link_waddr = rd_tail[AW-1:0];
          link_wdata = free_head;
        end
        done_next             = 1'b1;
        result_next.status    = sbmq_pkg::STATUS_DONE;
        result_next.pop_value = '0;
        state_next            = sbmq_pkg::S_IDLE;
      end

      // Check the queue and fetch the head's link and data.
      sbmq_pkg::S_POP_RD: begin
        if (!is_entry(rd_head)) begin
          done_next             = 1'b1;
          result_next.status    = sbmq_pkg::STATUS_UNDERFLOW;
          result_next.pop_value = '0;
          state_next            = sbmq_pkg::S_IDLE;
        end else begin
          link_raddr    = rd_head[AW-1:0];
          data_raddr    = rd_head[AW-1:0];
          pop_head_next = rd_head;
          pop_tail_next = rd_tail;
          state_next    = sbmq_pkg::S_POP_WR;
        end
      end

      // Unlink the head and return it to the front of the free list.
      sbmq_pkg::S_POP_WR: begin
        q_we           = 1'b1;
        q_wdata        = {link_next_head, pop_tail};
        link_we        = 1'b1;
        link_waddr     = pop_head[AW-1:0];
        link_wdata     = free_head;
        free_head_next = pop_head;
        done_next             = 1'b1;
        result_next.status    = sbmq_pkg::STATUS_DONE;
        result_next.pop_value = 32'($signed(data_rdata));
        state_next            = sbmq_pkg::S_IDLE;
      end

      default: begin
        state_next = sbmq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// Shared buffer multi-queue testbench
// Sends push and pop transactions to the multi-queue unit and checks every
// result against a shadow copy of the linked lists kept in the testbench.
// A short directed sequence covers the value extremes, empty queues and
// reuse of an emptied queue. Random phases then fill the store until it
// overflows and drain queues until they underflow, with random idle gaps.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES = sbmq_pkg::ENTRIES_DEF;
  localparam int QUEUES = sbmq_pkg::QUEUES_DEF;
  localparam logic [6:0] NIL = 7'(ENTRIES);
  localparam int RANDOM_ITEMS = 1850;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 10;

  // One queued transaction and the idle cycles that follow its acceptance.
  typedef struct {
    sbmq_pkg::op_t op_word;
    int            idle_after;
  } op_slot_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  sbmq_pkg::op_t     op = '0;
  logic              done;
  sbmq_pkg::result_t result;

  // Shadow copy of the unit's lists.
  logic [31:0] entry_word [ENTRIES];
  logic [6:0]  next_slot [ENTRIES];
  logic [6:0]  q_first [QUEUES];
  logic [6:0]  q_last [QUEUES];
  logic [6:0]  free_first;

  op_slot_t          op_backlog[$];
  sbmq_pkg::result_t answer_queue[$];
  int                mismatch_count = 0;
  int                cycle_count = 0;
  int                idle_left = 0;

  shared_buffer_multi_queue_unit dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .op     (op),
    .done   (done),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bring the shadow lists to their state after reset.
  task automatic clear_shadow();
    for (int i = 0; i < ENTRIES; i++) begin
      entry_word[i] = '0;
      next_slot[i] = 7'(i + 1);
    end
    for (int i = 0; i < QUEUES; i++) begin
      q_first[i] = NIL;
      q_last[i] = NIL;
    end
    free_first = '0;
  endtask

  // Apply one transaction to the shadow lists and return its answer.
  function automatic sbmq_pkg::result_t predict_answer(sbmq_pkg::op_t o);
    sbmq_pkg::result_t r;
    logic [6:0]        slot;
    int                q;
    r.status = sbmq_pkg::STATUS_DONE;
    r.pop_value = '0;
    q = int'(o.queue_number);
    if (o.command == sbmq_pkg::CMD_PUSH) begin
      if (free_first >= NIL) begin
        r.status = sbmq_pkg::STATUS_OVERFLOW;
      end else begin
        slot = free_first;
        free_first = next_slot[slot];
        if (q_first[q] >= NIL) begin
          q_first[q] = slot;
        end else if (q_last[q] < NIL) begin
          next_slot[q_last[q]] = slot;
        end
        next_slot[slot] = NIL;
        q_last[q] = slot;
        entry_word[slot] = o.push_value;
      end
    end else begin
      if (q_first[q] >= NIL) begin
        r.status = sbmq_pkg::STATUS_UNDERFLOW;
      end else begin
        slot = q_first[q];
        q_first[q] = (next_slot[slot] < NIL) ? next_slot[slot] : NIL;
        next_slot[slot] = free_first;
        free_first = slot;
        r.pop_value = entry_word[slot];
      end
    end
    return r;
  endfunction

  task automatic add_op(sbmq_pkg::command_t cmd, int q, logic [31:0] value, int idle);
    op_slot_t s;
    s.op_word.command = cmd;
    s.op_word.queue_number = 3'(q);
    s.op_word.push_value = value;
    s.idle_after = idle;
    op_backlog.push_back(s);
  endtask

  // Idle length: style 0 never idles, style 1 mostly short with a few long.
  function automatic int pick_idle(int style);
    int r;
    if (style == 0) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(4, 1);
    return $urandom_range(40, 8);
  endfunction

  // Stimulus: directed sequence, then random push-heavy and pop-heavy phases.
  initial begin
    int made;
    int push_pct;
    int phase_len;
    int style;
    int narrow;
    int base_q;
    int q;
    clear_shadow();

    // Pops of empty queues, the first with a nonzero value that must be ignored.
    add_op(sbmq_pkg::CMD_POP, 0, 32'hDEAD_BEEF, 0);
    add_op(sbmq_pkg::CMD_POP, 7, 32'h0000_0000, 1);
    // Value extremes and alternating bit patterns.
    add_op(sbmq_pkg::CMD_PUSH, 0, 32'h7FFF_FFFF, 0);
    add_op(sbmq_pkg::CMD_PUSH, 0, 32'h8000_0000, 0);
    add_op(sbmq_pkg::CMD_PUSH, 7, 32'hFFFF_FFFF, 2);
    add_op(sbmq_pkg::CMD_PUSH, 7, 32'h0000_0000, 0);
    add_op(sbmq_pkg::CMD_PUSH, 3, 32'hAAAA_AAAA, 0);
    add_op(sbmq_pkg::CMD_PUSH, 3, 32'h5555_5555, 3);
    // First-in first-out order, then emptying queue 0 so its tail goes stale.
    add_op(sbmq_pkg::CMD_POP, 0, 32'h0, 0);
    add_op(sbmq_pkg::CMD_POP, 0, 32'h0, 0);
    add_op(sbmq_pkg::CMD_POP, 0, 32'h0, 1);
    // A push to the emptied queue must start a fresh list.
    add_op(sbmq_pkg::CMD_PUSH, 0, 32'h1234_5678, 0);
    add_op(sbmq_pkg::CMD_PUSH, 0, 32'hFEDC_BA98, 0);
    add_op(sbmq_pkg::CMD_POP, 7, 32'h0, 0);
    add_op(sbmq_pkg::CMD_POP, 3, 32'h0, 0);
    add_op(sbmq_pkg::CMD_POP, 7, 32'h0, 2);
    add_op(sbmq_pkg::CMD_POP, 3, 32'h0, 0);
    add_op(sbmq_pkg::CMD_POP, 0, 32'h0, 0);
    add_op(sbmq_pkg::CMD_POP, 0, 32'h0, 0);
    add_op(sbmq_pkg::CMD_PUSH, 5, 32'h0000_0001, 0);
    add_op(sbmq_pkg::CMD_POP, 5, 32'hFFFF_FFFF, 0);
    add_op(sbmq_pkg::CMD_POP, 5, 32'h0, 0);

    // Fill the whole store, then two pushes that must overflow.
    for (int i = 0; i < ENTRIES; i++) begin
      add_op(sbmq_pkg::CMD_PUSH, $urandom_range(QUEUES - 1), $urandom, pick_idle(i / 32));
    end
    add_op(sbmq_pkg::CMD_PUSH, 2, $urandom, 0);
    add_op(sbmq_pkg::CMD_PUSH, 6, $urandom, 1);
    made = ENTRIES + 2;

    // Random phases swing the fill level between full and empty.
    while (made < RANDOM_ITEMS) begin
      case ($urandom_range(2))
        0: push_pct = 85;
        1: push_pct = 50;
        default: push_pct = 15;
      endcase
      phase_len = $urandom_range(160, 40);
      style = ($urandom_range(3) == 0) ? 0 : 1;
      narrow = ($urandom_range(2) == 0);
      base_q = $urandom_range(QUEUES - 1);
      for (int i = 0; i < phase_len; i++) begin
        q = narrow ? ((base_q + $urandom_range(1)) % QUEUES) : $urandom_range(QUEUES - 1);
        if ($urandom_range(99) < push_pct) begin
          add_op(sbmq_pkg::CMD_PUSH, q, $urandom, pick_idle(style));
        end else begin
          add_op(sbmq_pkg::CMD_POP, q, $urandom, pick_idle(style));
        end
      end
      made += phase_len;
    end

    // Hold reset, then release it.
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Wait until every transaction is sent and every result has come back.
    do begin
      @(posedge clk);
    end while (op_backlog.size() != 0 || answer_queue.size() != 0 || start);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Driver: presents the oldest pending transaction, predicts on acceptance.
  always @(posedge clk) begin
    logic go;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        answer_queue.push_back(predict_answer(op));
        idle_left = op_backlog[0].idle_after;
        op_backlog.pop_front();
      end
      if (idle_left > 0) begin
        idle_left--;
        go = 1'b0;
      end else begin
        go = (op_backlog.size() != 0);
      end
      start <= go;
      if (go) begin
        op <= op_backlog[0].op_word;
      end
    end
  end

  // Monitor: compares every result with the oldest predicted answer.
  always @(posedge clk) begin
    sbmq_pkg::result_t want;
    if (!rst && done) begin
      if (answer_queue.size() == 0) begin
        $display("%0t: unexpected result status=%0d value=%h", $time,
                 result.status, result.pop_value);
        mismatch_count++;
      end else begin
        want = answer_queue.pop_front();
        if (result.status != want.status) begin
          $display("%0t: status mismatch expected=%0d actual=%0d", $time,
                   want.status, result.status);
          mismatch_count++;
        end
        if (result.pop_value !== want.pop_value) begin
          $display("%0t: pop_value mismatch expected=%h actual=%h", $time,
                   want.pop_value, result.pop_value);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
